// File: hdl/ams_pkg.sv
// ----------------------------------------------------------------------------
// ams_pkg
// Shared types and constants for the decimal-coded accumulator machine.
// ----------------------------------------------------------------------------
`default_nettype none
package ams_pkg;

  localparam int WORD_WIDTH = 16;
  localparam int MEM_DEPTH  = 256;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int PC_W       = 9;
  localparam int OPC_W      = 7;
  localparam int OPND_W     = 7;
  localparam int OP_W       = 9;

  // floor(w / 100) = (w * RECIP) >> RECIP_SHIFT for 0 <= w < 32768
  localparam int RECIP       = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = 13;
  localparam int DEC_BASE    = 100;
  localparam int MAX_OPC     = 99;
  localparam int COMP_BASE   = 255;

  typedef enum logic [2:0] {
    ST_LOADED   = 3'd0,
    ST_EXECUTED = 3'd1,
    ST_HALTED   = 3'd2,
    ST_PAST_END = 3'd3,
    ST_UNKNOWN  = 3'd4,
    ST_DIVZERO  = 3'd5
  } status_t;

  localparam logic [OP_W-1:0] OP_READ  = 9'd10;
  localparam logic [OP_W-1:0] OP_WRITE = 9'd11;
  localparam logic [OP_W-1:0] OP_LOAD  = 9'd20;
  localparam logic [OP_W-1:0] OP_STORE = 9'd21;
  localparam logic [OP_W-1:0] OP_ADD   = 9'd30;
  localparam logic [OP_W-1:0] OP_SUB   = 9'd31;
  localparam logic [OP_W-1:0] OP_DIV   = 9'd32;
  localparam logic [OP_W-1:0] OP_MUL   = 9'd33;
  localparam logic [OP_W-1:0] OP_COMP  = 9'd34;
  localparam logic [OP_W-1:0] OP_INC   = 9'd35;
  localparam logic [OP_W-1:0] OP_DEC   = 9'd36;
  localparam logic [OP_W-1:0] OP_JUMP  = 9'd40;
  localparam logic [OP_W-1:0] OP_JNEG  = 9'd41;
  localparam logic [OP_W-1:0] OP_HALT  = 9'd99;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic check;
    logic fetch;
    logic decode;
    logic exec;
    logic div_end;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic kind;
    logic halted;
    logic past_end;
    logic word_neg;
    logic div_go;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: hdl/ams_div.sv
// ----------------------------------------------------------------------------
// ams_div
// Iterative signed divider, truncating; one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ams_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [ams_pkg::WORD_WIDTH-1:0] dividend,
  input  wire logic [ams_pkg::WORD_WIDTH-1:0] divisor,
  output logic                                done,
  output logic      [ams_pkg::WORD_WIDTH-1:0] quot
);

  localparam int W   = ams_pkg::WORD_WIDTH;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     q;
  logic [W-1:0]     rem;
  logic [W-1:0]     dmag;
  logic             qneg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [W:0]       trial;
  logic             fits;

  // shift one dividend bit into the partial remainder
  assign trial = {rem, q[W-1]};
  assign fits  = trial >= {1'b0, dmag};
  assign quot  = qneg ? (~q + W'(1)) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // magnitudes on start, then one restoring step a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      q    <= dividend[W-1] ? (~dividend + W'(1)) : dividend;
      dmag <= divisor[W-1] ? (~divisor + W'(1)) : divisor;
      qneg <= dividend[W-1] ^ divisor[W-1];
      rem  <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= W'(trial - {1'b0, dmag});
      end else begin
        rem <= trial[W-1:0];
      end
      q <= {q[W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// File: hdl/ams_ctrl.sv
// ----------------------------------------------------------------------------
// ams_ctrl
// Sequencer: steps one item through check, fetch, decode, execute, respond.
// ----------------------------------------------------------------------------
`default_nettype none
module ams_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire ams_pkg::stat_t stat,
  output ams_pkg::cmd_t       cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_FETCH = 8'b0000_0100,
    S_DEC   = 8'b0000_1000,
    S_RDOP  = 8'b0001_0000,
    S_EXEC  = 8'b0010_0000,
    S_DIVW  = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.capture = s_tvalid;
        if (s_tvalid) state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (!stat.kind || stat.halted || stat.past_end) begin
          state_next = S_RESP;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = stat.word_neg ? S_RESP : S_DEC;
      end
      S_DEC: begin
        cmd.decode = 1'b1;
        state_next = S_RDOP;
      end
      S_RDOP: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.div_go ? S_DIVW : S_RESP;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          cmd.div_end = 1'b1;
          state_next  = S_RESP;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ams_dpath.sv
// ----------------------------------------------------------------------------
// ams_dpath
// Machine state, word memory, decode, arithmetic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module ams_dpath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ams_pkg::cmd_t  cmd,
  output ams_pkg::stat_t      stat,
  input  wire logic [23:0]    s_tdata,
  input  wire logic [0:0]     s_tuser,
  input  wire logic           cfg_wen,
  input  wire logic [8:0]     cfg_wdata,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [55:0]         m_tdata,
  output logic [2:0]          m_tuser
);

  localparam int W  = ams_pkg::WORD_WIDTH;
  localparam int AW = ams_pkg::ADDR_W;
  localparam int PW = ams_pkg::PC_W;
  localparam int OW = ams_pkg::OP_W;
  localparam int NW = ams_pkg::OPND_W;

  // item and configuration
  logic          item_kind;
  logic [AW-1:0] item_addr;
  logic [W-1:0]  item_val;
  logic [PW-1:0] plen;

  // machine state
  logic [W-1:0]  acc;
  logic          neg;
  logic [PW-1:0] pc;
  logic          halted;

  // memory and decode
  logic [W-1:0]  mem [ams_pkg::MEM_DEPTH];
  logic [W-1:0]  rdata;
  logic [W-1:0]  word;
  logic [OW-1:0] op;
  logic [NW-1:0] opnd;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [W-1:0]  mem_wd;

  // result under construction
  ams_pkg::status_t       res_status;
  logic [ams_pkg::OPC_W-1:0] res_opc;
  logic                   res_ov;
  logic [W-1:0]           res_ow;

  // arithmetic
  logic [W+ams_pkg::RECIP_W-2:0] quot_full;
  logic [OW-1:0]  op_calc;
  logic [W-1:0]   op_x100;
  logic [W-1:0]   rem_full;
  logic [W-1:0]   sum;
  logic [W-1:0]   diff;
  logic [2*W-1:0] prod;
  logic [W-1:0]   ld_val;
  logic           div_zero;
  logic           div_m1;
  logic           div_done;
  logic [W-1:0]   div_q;
  logic           past_end;

  // execute effects
  logic [W-1:0]          acc_x;
  logic                  neg_x;
  logic [PW-1:0]         pc_x;
  logic                  halt_x;
  ams_pkg::status_t      status_x;
  logic                  ov_x;

  assign past_end = (pc >= plen) || (pc >= PW'(ams_pkg::MEM_DEPTH));

  // status toward the sequencer
  always_comb begin
    stat          = '0;
    stat.kind     = item_kind;
    stat.halted   = halted;
    stat.past_end = past_end;
    stat.word_neg = rdata[W-1];
    stat.div_go   = (op == ams_pkg::OP_DIV) && !div_zero && !div_m1;
    stat.div_done = div_done;
    stat.out_free = !m_tvalid || m_tready;
  end

  // divide the fetched word by one hundred
  assign quot_full = rdata[W-2:0] * ams_pkg::RECIP_W'(ams_pkg::RECIP);
  assign op_calc   = quot_full[ams_pkg::RECIP_SHIFT +: OW];
  assign op_x100   = W'(op) * W'(ams_pkg::DEC_BASE);
  assign rem_full  = word - op_x100;

  // memory ports
  assign rd_addr = cmd.check ? pc[AW-1:0] : AW'(opnd);
  assign mem_we  = (cmd.check && !item_kind) ||
                   (cmd.exec && (op == ams_pkg::OP_READ || op == ams_pkg::OP_STORE));
  assign mem_wa  = cmd.check ? item_addr : AW'(opnd);
  assign mem_wd  = (cmd.check || op == ams_pkg::OP_READ) ? item_val : acc;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata <= mem[rd_addr];
  end

  // operand arithmetic
  assign sum      = acc + rdata;
  assign diff     = acc - rdata;
  assign prod     = acc * rdata;
  assign div_zero = (rdata == '0);
  assign div_m1   = (rdata == '1);

  always_comb begin
    case (op)
      ams_pkg::OP_ADD: ld_val = sum;
      ams_pkg::OP_SUB: ld_val = diff;
      default:         ld_val = rdata;
    endcase
  end

  // work out the effect of the decoded instruction
  always_comb begin
    acc_x    = acc;
    neg_x    = neg;
    pc_x     = pc;
    halt_x   = 1'b0;
    status_x = ams_pkg::ST_EXECUTED;
    ov_x     = 1'b0;
    case (op)
      ams_pkg::OP_READ, ams_pkg::OP_STORE: ;
      ams_pkg::OP_WRITE: ov_x = 1'b1;
      ams_pkg::OP_LOAD, ams_pkg::OP_ADD, ams_pkg::OP_SUB: begin
        acc_x = ld_val[W-1] ? (ld_val + W'(ams_pkg::COMP_BASE)) : ld_val;
        neg_x = ld_val[W-1];
      end
      ams_pkg::OP_DIV: begin
        if (div_zero) begin
          status_x = ams_pkg::ST_DIVZERO;
          halt_x   = 1'b1;
        end else if (div_m1) begin
          acc_x = ~acc + W'(1);
        end
      end
      ams_pkg::OP_MUL:  acc_x = prod[W-1:0];
      ams_pkg::OP_COMP: acc_x = W'(ams_pkg::COMP_BASE) - acc;
      ams_pkg::OP_INC:  acc_x = acc + W'(1);
      ams_pkg::OP_DEC:  acc_x = acc - W'(1);
      ams_pkg::OP_JUMP: pc_x = PW'(opnd);
      ams_pkg::OP_JNEG: if (neg) pc_x = PW'(opnd);
      ams_pkg::OP_HALT: begin
        status_x = ams_pkg::ST_HALTED;
        halt_x   = 1'b1;
      end
      default: begin
        status_x = ams_pkg::ST_UNKNOWN;
        halt_x   = 1'b1;
      end
    endcase
  end

  // machine state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      plen   <= '0;
      acc    <= '0;
      neg    <= 1'b0;
      pc     <= '0;
      halted <= 1'b0;
    end else begin
      if (cfg_wen) plen <= cfg_wdata;
      if (cmd.fetch) begin
        pc <= pc + PW'(1);
        if (rdata[W-1]) halted <= 1'b1;
      end
      if (cmd.exec) begin
        acc <= acc_x;
        neg <= neg_x;
        pc  <= pc_x;
        if (halt_x) halted <= 1'b1;
      end
      if (cmd.div_end) acc <= div_q;
    end
  end

  // item capture, decode registers and the result under construction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_kind <= s_tuser[0];
      item_addr <= s_tdata[AW-1:0];
      item_val  <= s_tdata[23:8];
    end
    if (cmd.check) begin
      res_opc <= '0;
      res_ov  <= 1'b0;
      res_ow  <= '0;
      if (!item_kind)       res_status <= ams_pkg::ST_LOADED;
      else if (halted)      res_status <= ams_pkg::ST_HALTED;
      else if (past_end)    res_status <= ams_pkg::ST_PAST_END;
      else                  res_status <= ams_pkg::ST_EXECUTED;
    end
    if (cmd.fetch) begin
      word <= rdata;
      op   <= op_calc;
      if (rdata[W-1]) res_status <= ams_pkg::ST_UNKNOWN;
    end
    if (cmd.decode) opnd <= rem_full[NW-1:0];
    if (cmd.exec) begin
      res_status <= status_x;
      res_opc    <= (op <= OW'(ams_pkg::MAX_OPC)) ? op[ams_pkg::OPC_W-1:0] : '0;
      res_ov     <= ov_x;
      if (ov_x) res_ow <= rdata;
    end
  end

  ams_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.exec && stat.div_go),
    .dividend (acc),
    .divisor  (rdata),
    .done     (div_done),
    .quot     (div_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tuser <= res_status;
      m_tdata <= {6'd0, res_ow, res_ov, neg, acc, pc, res_opc};
    end
  end

endmodule
`default_nettype wire

// File: hdl/accumulator_machine_step.sv
// ----------------------------------------------------------------------------
// accumulator_machine_step
// Decimal-coded accumulator machine: load words, execute one step per item.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  s_*      in         tuser: kind; tdata: address, value
//  m_*      out        tuser: status; tdata: opcode, pc, accumulator,
//                      negative, out_valid, out_word
//  cfg_*    in         program_length write
//
// A load item, or a halted or past-end step, goes from check to respond; a
// negative (unknown) word via fetch; an executed step via fetch, decode,
// operand read and execute (a divide then waits on the 16-step shift/subtract unit).
// One item is in flight at a time; the sequencer returns to idle once the
// result is in the output register. rst is synchronous; the word memory
// holds no reset value. A stalled m_tready holds the sequencer in respond.
// ----------------------------------------------------------------------------
`default_nettype none
module accumulator_machine_step (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // address[7:0], value[23:8]
  input  wire logic [0:0]  s_tuser,   // kind[0]
  input  wire logic        cfg_wen,
  input  wire logic [8:0]  cfg_wdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // opcode[6:0], pc[15:7], accumulator[31:16],
                                      // negative[32], out_valid[33],
                                      // out_word[49:34], zero[55:50]
  output logic [2:0]       m_tuser    // status[2:0]
);

  ams_pkg::cmd_t  cmd;
  ams_pkg::stat_t stat;

  ams_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ams_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire
